@@ rtl/tgr_pkg.sv @@
`default_nettype none

package tgr_pkg;

	localparam int DISPLAY_WIDTH  = 240;
	localparam int DISPLAY_HEIGHT = 240;

	localparam int LONG_PRESS_RESET = 500;
	localparam int SWIPE_TH_RESET   = 50;

	// register indexes of the configuration port
	localparam logic CFG_LONG_PRESS = 1'b0;
	localparam logic CFG_SWIPE_TH   = 1'b1;

	typedef enum logic [3:0] {
		EV_NONE  = 4'd0,
		EV_PRESS = 4'd1,
		EV_MOVE  = 4'd2,
		EV_TAP   = 4'd3,
		EV_LONG  = 4'd4,
		EV_LEFT  = 4'd5,
		EV_RIGHT = 4'd6,
		EV_UP    = 4'd7,
		EV_DOWN  = 4'd8
	} event_kind_t;

	// one poll after coordinate mapping
	typedef struct packed {
		logic        read_ok;
		logic        touched;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [31:0] time_ms;
	} tgr_item_t;

	typedef struct packed {
		logic [7:0]  pointer_x;
		logic [7:0]  pointer_y;
		logic        pressed;
		event_kind_t kind;
		logic        last;
	} tgr_result_t;

	// results of one poll toward the output queue
	typedef struct packed {
		logic        push;
		logic        two;
		tgr_result_t first;
		tgr_result_t second;
	} tgr_push_t;

	// invert against the display size and clamp to 0..size-1, keep low 8 bits
	function automatic logic [7:0] map_coord(input logic [11:0] raw, input logic [12:0] size);
		logic signed [13:0] v;
		logic signed [13:0] top_v;
		v     = $signed({1'b0, size}) - $signed({2'b00, raw});
		top_v = $signed({1'b0, size}) - 14'sd1;
		if (v < 14'sd0) begin
			v = 14'sd0;
		end
		if (v > top_v) begin
			v = top_v;
		end
		return v[7:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/tgr_core.sv @@
`default_nettype none

module tgr_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire tgr_pkg::tgr_item_t  item,
	input  wire logic [15:0]         long_press_ms,
	input  wire logic [17:0]         swipe_th_sq,
	output tgr_pkg::tgr_push_t       push
);

	logic        touched_q, gesture_q;
	logic [31:0] press_time_q;
	logic [7:0]  anchor_x_q, anchor_y_q, held_x_q, held_y_q;

	logic        touched_n, gesture_n;
	logic [31:0] press_time_n;
	logic [7:0]  anchor_x_n, anchor_y_n, held_x_n, held_y_n;

	logic signed [8:0]  dx, dy;
	logic [7:0]         adx, ady;
	logic [16:0]        sq_x, sq_y;
	logic [17:0]        dist_sq;
	logic               swipe;
	tgr_pkg::event_kind_t swipe_kind;
	logic [31:0]        duration;

	assign dx      = $signed({1'b0, item.x}) - $signed({1'b0, anchor_x_q});
	assign dy      = $signed({1'b0, item.y}) - $signed({1'b0, anchor_y_q});
	assign adx     = dx[8] ? 8'(-dx) : dx[7:0];
	assign ady     = dy[8] ? 8'(-dy) : dy[7:0];
	assign sq_x    = 17'({9'd0, adx} * {9'd0, adx});
	assign sq_y    = 17'({9'd0, ady} * {9'd0, ady});
	assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
	assign swipe   = dist_sq > swipe_th_sq;
	assign duration = item.time_ms - press_time_q;

	always_comb begin
		if (adx > ady) begin
			swipe_kind = (dx > 9'sd0) ? tgr_pkg::EV_RIGHT : tgr_pkg::EV_LEFT;
		end else begin
			swipe_kind = (dy > 9'sd0) ? tgr_pkg::EV_DOWN : tgr_pkg::EV_UP;
		end
	end

	always_comb begin
		touched_n    = touched_q;
		gesture_n    = gesture_q;
		press_time_n = press_time_q;
		anchor_x_n   = anchor_x_q;
		anchor_y_n   = anchor_y_q;
		held_x_n     = held_x_q;
		held_y_n     = held_y_q;
		push.push    = fire;
		push.two     = 1'b0;
		push.first   = '{held_x_q, held_y_q, 1'b0, tgr_pkg::EV_NONE, 1'b1};
		push.second  = '{item.x, item.y, 1'b1, tgr_pkg::EV_MOVE, 1'b1};
		if (!item.read_ok) begin
			touched_n = 1'b0;
		end else if (item.touched) begin
			held_x_n  = item.x;
			held_y_n  = item.y;
			touched_n = 1'b1;
			if (!gesture_q) begin
				gesture_n    = 1'b1;
				press_time_n = item.time_ms;
				anchor_x_n   = item.x;
				anchor_y_n   = item.y;
				push.first   = '{item.x, item.y, 1'b1, tgr_pkg::EV_PRESS, 1'b1};
			end else if (swipe) begin
				anchor_x_n = item.x;
				anchor_y_n = item.y;
				push.two   = 1'b1;
				push.first = '{item.x, item.y, 1'b1, swipe_kind, 1'b0};
			end else begin
				push.first = '{item.x, item.y, 1'b1, tgr_pkg::EV_MOVE, 1'b1};
			end
		end else if (touched_q) begin
			touched_n = 1'b0;
			if (gesture_q) begin
				gesture_n  = 1'b0;
				push.first = '{held_x_q, held_y_q, 1'b0,
					(duration >= {16'd0, long_press_ms}) ? tgr_pkg::EV_LONG : tgr_pkg::EV_TAP,
					1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q    <= 1'b0;
			gesture_q    <= 1'b0;
			press_time_q <= '0;
			anchor_x_q   <= '0;
			anchor_y_q   <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
		end else if (fire) begin
			touched_q    <= touched_n;
			gesture_q    <= gesture_n;
			press_time_q <= press_time_n;
			anchor_x_q   <= anchor_x_n;
			anchor_y_q   <= anchor_y_n;
			held_x_q     <= held_x_n;
			held_y_q     <= held_y_n;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tgr_outq.sv @@
`default_nettype none

module tgr_outq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tgr_pkg::tgr_push_t   push,
	input  wire logic                 pop,
	output logic                      room,
	output logic                      head_valid,
	output tgr_pkg::tgr_result_t      head
);

	tgr_pkg::tgr_result_t mem_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic [1:0] wr_ptr_1;
	logic [2:0] n_push;
	logic [2:0] n_pop;

	assign wr_ptr_1   = wr_ptr_q + 2'd1;
	assign n_push     = push.push ? (push.two ? 3'd2 : 3'd1) : 3'd0;
	assign n_pop      = pop ? 3'd1 : 3'd0;
	// room for a whole poll's results
	assign room       = count_q <= 3'd2;
	assign head_valid = count_q != 3'd0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.first;
			if (push.two) begin
				mem_q[wr_ptr_1] <= push.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[1:0];
			rd_ptr_q <= rd_ptr_q + n_pop[1:0];
			count_q  <= count_q + n_push - n_pop;
		end
	end

endmodule

`default_nettype wire

@@ rtl/touch_gesture_recognizer.sv @@
// A poll accepted is held in the input register, then passes through the gesture core
// into the result queue once that has room; its first result is offered from the queue head.
// Throughput: one poll per cycle and one result per cycle while the output is not stalled;
// a poll that swipes yields two results. The single output port sets this; a poll
// advances only while the four-entry result queue has room for two results.
// Reset (arst_n low, asynchronous): gesture state and queue clear, long_press_ms returns
// to 500 and the swipe distance bound to 50.
`default_nettype none

module touch_gesture_recognizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [15:0] cfg_wdata,
	// poll input
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        read_ok,
	input  wire logic [7:0]  touch_count,
	input  wire logic [11:0] raw_x,
	input  wire logic [11:0] raw_y,
	input  wire logic [31:0] time_ms,
	// result output
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       pointer_x,
	output logic [7:0]       pointer_y,
	output logic             pressed,
	output logic [3:0]       event_kind,
	output logic             last
);

	// configuration; the threshold is kept squared so the distance test is one compare
	logic [15:0] long_press_q;
	logic [17:0] swipe_th_sq_q;

	// input register
	logic                 valid_s1;
	tgr_pkg::tgr_item_t   item_s1;

	logic                 in_accept;
	logic                 advance;
	logic                 room;
	tgr_pkg::tgr_push_t   push;
	tgr_pkg::tgr_result_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q  <= 16'(tgr_pkg::LONG_PRESS_RESET);
			swipe_th_sq_q <= 18'(tgr_pkg::SWIPE_TH_RESET * tgr_pkg::SWIPE_TH_RESET);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tgr_pkg::CFG_LONG_PRESS: long_press_q <= cfg_wdata;
				tgr_pkg::CFG_SWIPE_TH: swipe_th_sq_q <=
					18'({9'd0, cfg_wdata[8:0]} * {9'd0, cfg_wdata[8:0]});
			endcase
		end
	end

	// Advance the held poll once the queue can take both of its possible results;
	// stall the input only while a poll waits in the input register without room.
	assign advance   = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Map coordinates on the way in so the gesture stage sees display pixels.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.read_ok <= read_ok;
			item_s1.touched <= touch_count != 8'd0;
			item_s1.x       <= tgr_pkg::map_coord(raw_x, 13'(tgr_pkg::DISPLAY_WIDTH));
			item_s1.y       <= tgr_pkg::map_coord(raw_y, 13'(tgr_pkg::DISPLAY_HEIGHT));
			item_s1.time_ms <= time_ms;
		end
	end

	// Gesture state and result generation for one poll per cycle while the result queue has room.
	tgr_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.item         (item_s1),
		.long_press_ms(long_press_q),
		.swipe_th_sq  (swipe_th_sq_q),
		.push         (push)
	);

	// Result queue: separates the output handshake from the gesture stage.
	tgr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_valid && !out_stall),
		.room      (room),
		.head_valid(out_valid),
		.head      (head)
	);

	assign pointer_x  = head.pointer_x;
	assign pointer_y  = head.pointer_y;
	assign pressed    = head.pressed;
	assign event_kind = head.kind;
	assign last       = head.last;

endmodule

`default_nettype wire

@@ rtl/tgr_checker.sv @@
`default_nettype none

module tgr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] pointer_x,
	input wire logic [7:0] pointer_y,
	input wire logic       pressed,
	input wire logic [3:0] event_kind,
	input wire logic       last
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// a non-final result is a swipe and its move follows at once
	a_swipe_then_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && last &&
		event_kind == tgr_pkg::EV_MOVE)
		else $error("swipe not followed by move");

	a_nonlast_swipe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> pressed && (event_kind == tgr_pkg::EV_LEFT ||
		event_kind == tgr_pkg::EV_RIGHT || event_kind == tgr_pkg::EV_UP ||
		event_kind == tgr_pkg::EV_DOWN))
		else $error("non-final result is not a pressed swipe");

	// released events carry pressed low, touch events pressed high
	a_pressed_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pressed == !(event_kind == tgr_pkg::EV_NONE ||
		event_kind == tgr_pkg::EV_TAP || event_kind == tgr_pkg::EV_LONG))
		else $error("pressed disagrees with event");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pointer_x < 8'(tgr_pkg::DISPLAY_WIDTH) &&
		pointer_y < 8'(tgr_pkg::DISPLAY_HEIGHT))
		else $error("pointer outside display");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pointer_x (pointer_x),
	.pointer_y (pointer_y),
	.pressed   (pressed),
	.event_kind(event_kind),
	.last      (last)
);

`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none

module tb_top;

	// Longest stretch without any accepted transaction before the run is called hung.
	localparam int QUIET_LIMIT = 3000;
	// Length of the forced output back-pressure in the pressure phase.
	localparam int LONG_HOLD   = 120;
	localparam int PHASES      = 7;
	localparam int PHASE_POLLS = 250;

	typedef struct packed {
		logic        read_ok;
		logic [7:0]  touch_count;
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [31:0] time_ms;
	} poll_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        read_ok = 1'b0;
	logic [7:0]  touch_count = '0;
	logic [11:0] raw_x = '0;
	logic [11:0] raw_y = '0;
	logic [31:0] time_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  pointer_x;
	logic [7:0]  pointer_y;
	logic        pressed;
	logic [3:0]  event_kind;
	logic        last;

	// Polls waiting to be driven, and pointer events the recognizer still owes us.
	poll_t                poll_q[$];
	tgr_pkg::tgr_result_t due_q[$];
	poll_t                cur_poll;

	// Gesture tracker mirror: configuration copy and gesture state.
	logic [15:0] long_press_ms = 16'(tgr_pkg::LONG_PRESS_RESET);
	logic [8:0]  swipe_th = 9'(tgr_pkg::SWIPE_TH_RESET);
	logic        finger_down = 1'b0;
	logic        gesture_on = 1'b0;
	logic [31:0] press_ms = '0;
	logic [7:0]  anchor_x = '0;
	logic [7:0]  anchor_y = '0;
	logic [7:0]  held_x = '0;
	logic [7:0]  held_y = '0;

	// Traffic shaping knobs, set between phases by the sequencer.
	bit          sender_idle = 1'b0;
	bit          receiver_idle = 1'b0;
	int          hold_reqs = 0;
	int          holds_done = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          free_left = 0;
	int          quiet_cycles = 0;
	int          mismatches = 0;

	always #2 clk = ~clk;

	touch_gesture_recognizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.read_ok    (read_ok),
		.touch_count(touch_count),
		.raw_x      (raw_x),
		.raw_y      (raw_y),
		.time_ms    (time_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pointer_x  (pointer_x),
		.pointer_y  (pointer_y),
		.pressed    (pressed),
		.event_kind (event_kind),
		.last       (last)
	);

	// Idle run length: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Invert a raw coordinate against the screen size and clamp it to the screen.
	function automatic logic [7:0] screen_coord(input logic [11:0] raw, input int size);
		int v;
		v = size - int'(raw);
		if (v < 0) v = 0;
		if (v > size - 1) v = size - 1;
		return v[7:0];
	endfunction

	function automatic void owe_event(input logic [7:0] x, input logic [7:0] y,
			input logic down, input tgr_pkg::event_kind_t kind, input logic fin);
		tgr_pkg::tgr_result_t r;
		r.pointer_x = x;
		r.pointer_y = y;
		r.pressed   = down;
		r.kind      = kind;
		r.last      = fin;
		due_q.push_back(r);
	endfunction

	// Advance the gesture tracker by one poll and queue the pointer events it yields.
	function automatic void track_gesture(input poll_t p);
		logic [7:0]           px;
		logic [7:0]           py;
		int                   dx;
		int                   dy;
		int                   adx;
		int                   ady;
		longint               dist2;
		longint               lim2;
		logic [31:0]          held_for;
		tgr_pkg::event_kind_t swipe;
		tgr_pkg::event_kind_t ending;
		if (!p.read_ok) begin
			// bus failure: report released but keep the gesture open
			finger_down = 1'b0;
			owe_event(held_x, held_y, 1'b0, tgr_pkg::EV_NONE, 1'b1);
		end else if (p.touch_count != 8'd0) begin
			px = screen_coord(p.raw_x, tgr_pkg::DISPLAY_WIDTH);
			py = screen_coord(p.raw_y, tgr_pkg::DISPLAY_HEIGHT);
			held_x = px;
			held_y = py;
			finger_down = 1'b1;
			if (!gesture_on) begin
				gesture_on = 1'b1;
				press_ms   = p.time_ms;
				anchor_x   = px;
				anchor_y   = py;
				owe_event(px, py, 1'b1, tgr_pkg::EV_PRESS, 1'b1);
			end else begin
				dx    = int'(px) - int'(anchor_x);
				dy    = int'(py) - int'(anchor_y);
				dist2 = longint'(dx) * dx + longint'(dy) * dy;
				lim2  = longint'(swipe_th) * longint'(swipe_th);
				if (dist2 > lim2) begin
					adx = (dx < 0) ? -dx : dx;
					ady = (dy < 0) ? -dy : dy;
					// ties go vertical, and a flat or upward delta is an up swipe
					if (adx > ady) begin
						if (dx > 0) swipe = tgr_pkg::EV_RIGHT;
						else swipe = tgr_pkg::EV_LEFT;
					end else begin
						if (dy > 0) swipe = tgr_pkg::EV_DOWN;
						else swipe = tgr_pkg::EV_UP;
					end
					owe_event(px, py, 1'b1, swipe, 1'b0);
					anchor_x = px;
					anchor_y = py;
				end
				owe_event(px, py, 1'b1, tgr_pkg::EV_MOVE, 1'b1);
			end
		end else if (finger_down && gesture_on) begin
			finger_down = 1'b0;
			gesture_on  = 1'b0;
			held_for    = p.time_ms - press_ms;
			if (held_for >= {16'd0, long_press_ms}) ending = tgr_pkg::EV_LONG;
			else ending = tgr_pkg::EV_TAP;
			owe_event(held_x, held_y, 1'b0, ending, 1'b1);
		end else begin
			// plain release, or release after a failed read: no ending, an open gesture stays open
			finger_down = 1'b0;
			owe_event(held_x, held_y, 1'b0, tgr_pkg::EV_NONE, 1'b1);
		end
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	// Poll driver: on an accepted transaction, update the tracker; present the next
	// poll as soon as the current one is gone, after an optional gap.
	always @(posedge clk) begin : drive_polls
		logic next_valid;
		if (in_valid && !in_stall) track_gesture(cur_poll);
		if (!in_valid || !in_stall) begin
			next_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (poll_q.size() != 0) begin
				cur_poll    = poll_q.pop_front();
				read_ok     <= cur_poll.read_ok;
				touch_count <= cur_poll.touch_count;
				raw_x       <= cur_poll.raw_x;
				raw_y       <= cur_poll.raw_y;
				time_ms     <= cur_poll.time_ms;
				next_valid  = 1'b1;
				gap_left    = sender_idle ? idle_len() : 0;
			end
			in_valid <= next_valid;
		end
	end

	// Output back-pressure: random stall/free runs, or one long hold on request.
	always @(posedge clk) begin : drive_stall
		logic next_stall;
		if (hold_reqs != holds_done) begin
			holds_done = hold_reqs;
			stall_left = LONG_HOLD;
			free_left  = 0;
		end
		next_stall = 1'b0;
		if (stall_left > 0) begin
			stall_left--;
			next_stall = 1'b1;
		end else if (free_left > 0) begin
			free_left--;
		end else if (receiver_idle) begin
			free_left  = $urandom_range(0, 12);
			stall_left = idle_len();
		end
		out_stall <= next_stall;
	end

	// Result monitor: compare each accepted transaction with the oldest owed event.
	always @(posedge clk) begin : check_events
		tgr_pkg::tgr_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_q.size() == 0) begin
				$error("unexpected result: x %0d y %0d pressed %0d kind %0d last %0d",
					pointer_x, pointer_y, pressed, event_kind, last);
				mismatches++;
			end else begin
				want = due_q.pop_front();
				check_field("pointer_x", 32'(want.pointer_x), 32'(pointer_x));
				check_field("pointer_y", 32'(want.pointer_y), 32'(pointer_y));
				check_field("pressed", 32'(want.pressed), 32'(pressed));
				check_field("event_kind", 32'(want.kind), 32'(event_kind));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	// Hang detector: drop the run once nothing moves on either channel for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic add_poll(input logic ok, input logic [7:0] cnt, input logic [11:0] rx,
			input logic [11:0] ry, input logic [31:0] t);
		poll_t p;
		p.read_ok     = ok;
		p.touch_count = cnt;
		p.raw_x       = rx;
		p.raw_y       = ry;
		p.time_ms     = t;
		poll_q.push_back(p);
	endtask

	// Hold until every poll went in and every owed event came out, then let the
	// pipeline settle. Returns on a falling edge.
	task automatic wait_drained();
		do @(negedge clk); while (poll_q.size() != 0 || in_valid || due_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Write one register while the block is idle; mirror it in the tracker.
	task automatic write_reg(input logic idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == tgr_pkg::CFG_LONG_PRESS) long_press_ms = value;
		else swipe_th = value[8:0];
		@(negedge clk);
	endtask

	initial begin : sequencer
		int          pick;
		int          moves;
		int          rx;
		int          ry;
		int          step;
		int          made;
		logic [31:0] t0;
		logic [31:0] dur;
		logic [31:0] clock_ms;
		logic [15:0] word;
		// start close to the top so the millisecond counter wraps early
		clock_ms = 32'hFFFF_0000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;

		// Directed part, reset configuration: long press 500 ms, swipe bound 50.
		add_poll(1'b1, 8'd0, 12'd0, 12'd0, 32'd10);              // idle release
		add_poll(1'b0, 8'hFF, 12'hFFF, 12'hFFF, 32'd20);         // failed read while idle
		add_poll(1'b1, 8'd1, 12'd0, 12'd0, 32'd1000);            // press, clamp to far corner
		add_poll(1'b1, 8'd2, 12'hFFF, 12'hFFF, 32'd1010);        // diagonal tie going up
		add_poll(1'b1, 8'd3, 12'd1, 12'd1, 32'd1020);            // diagonal tie going down
		add_poll(1'b1, 8'd4, 12'd240, 12'd1, 32'd1030);          // swipe left
		add_poll(1'b1, 8'd5, 12'd1, 12'd1, 32'd1040);            // swipe right
		add_poll(1'b1, 8'd6, 12'd51, 12'd1, 32'd1050);           // exactly on the bound
		add_poll(1'b1, 8'd7, 12'd52, 12'd1, 32'd1060);           // one past the bound
		add_poll(1'b1, 8'd8, 12'd52, 12'd52, 32'd1070);          // vertical up
		add_poll(1'b1, 8'd0, 12'd0, 12'd0, 32'd1499);            // one short of long press
		add_poll(1'b1, 8'd9, 12'd120, 12'd120, 32'd1500);
		add_poll(1'b1, 8'd0, 12'd0, 12'd0, 32'd2000);            // exactly long press
		add_poll(1'b1, 8'd1, 12'd200, 12'd30, 32'd3000);
		add_poll(1'b0, 8'd1, 12'd200, 12'd30, 32'd3100);         // failed read mid gesture
		add_poll(1'b1, 8'd0, 12'd0, 12'd0, 32'd9000);            // release after failed read
		add_poll(1'b1, 8'd1, 12'd100, 12'd100, 32'd9050);        // resumes the gesture: swipe right, then move
		add_poll(1'b1, 8'd0, 12'd0, 12'd0, 32'd9100);
		add_poll(1'b1, 8'd1, 12'd239, 12'd239, 32'hFFFF_FF00);   // press just before wrap
		add_poll(1'b1, 8'd0, 12'd0, 12'd0, 32'h0000_0010);       // release after wrap
		add_poll(1'b1, 8'h80, 12'd240, 12'd240, 32'd5);
		add_poll(1'b1, 8'h7F, 12'd240, 12'd240, 32'd6);          // move without travel
		add_poll(1'b1, 8'd0, 12'hABC, 12'h543, 32'd65540);       // long press at 65535 ms
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					// lower extremes: every release is long, any travel swipes
					write_reg(tgr_pkg::CFG_LONG_PRESS, 16'd0);
					write_reg(tgr_pkg::CFG_SWIPE_TH, 16'd0);
					sender_idle   = 1'b1;
					receiver_idle = 1'b1;
				end
				1: begin
					// upper extremes, with junk above the swipe field; no idling at all
					write_reg(tgr_pkg::CFG_LONG_PRESS, 16'hFFFF);
					word      = 16'($urandom);
					word[8:0] = 9'h1FF;
					write_reg(tgr_pkg::CFG_SWIPE_TH, word);
					sender_idle   = 1'b0;
					receiver_idle = 1'b0;
				end
				default: begin
					write_reg(tgr_pkg::CFG_LONG_PRESS,
						($urandom_range(0, 3) == 0) ? 16'($urandom) :
						16'($urandom_range(0, 1500)));
					word = 16'($urandom);
					if ($urandom_range(0, 3) != 0) word[8:0] = 9'($urandom_range(1, 100));
					write_reg(tgr_pkg::CFG_SWIPE_TH, word);
					sender_idle   = ($urandom_range(0, 3) != 0);
					receiver_idle = ($urandom_range(0, 3) != 0);
				end
			endcase
			if (p == 2) begin
				// pressure: the sender streams back to back while the output is held off
				sender_idle   = 1'b0;
				receiver_idle = 1'b1;
				hold_reqs++;
			end

			made = 0;
			while (made < PHASE_POLLS) begin
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					// gesture: press, a walk of moves and now and then a failed read, release
					rx = $urandom_range(0, 260);
					ry = $urandom_range(0, 260);
					t0 = clock_ms;
					add_poll(1'b1, 8'($urandom_range(1, 255)), 12'(rx), 12'(ry), t0);
					case ($urandom_range(0, 3))
						0: dur = {16'd0, long_press_ms};
						1: dur = {16'd0, long_press_ms} - 32'd1;
						2: dur = $urandom_range(0, 2 * int'(long_press_ms) + 20);
						default: dur = $urandom;
					endcase
					moves = $urandom_range(0, 6);
					repeat (moves) begin
						if ($urandom_range(0, 9) == 0) begin
							add_poll(1'b0, 8'($urandom), 12'($urandom), 12'($urandom),
								t0 + $urandom_range(0, 400));
						end else begin
							if ($urandom_range(0, 7) == 0) begin
								rx = $urandom_range(0, 4095);
								ry = $urandom_range(0, 4095);
							end else begin
								step = $urandom_range(0, 160);
								rx   = rx + step - 80;
								step = $urandom_range(0, 160);
								ry   = ry + step - 80;
								if (rx < 0) rx = 0;
								if (rx > 300) rx = 300;
								if (ry < 0) ry = 0;
								if (ry > 300) ry = 300;
							end
							add_poll(1'b1, 8'($urandom_range(1, 255)), 12'(rx), 12'(ry),
								t0 + $urandom_range(0, 400));
						end
					end
					add_poll(1'b1, 8'd0, 12'($urandom), 12'($urandom), t0 + dur);
					clock_ms = t0 + dur + $urandom_range(1, 2000);
					made += moves + 2;
				end else if (pick < 90) begin
					// noise: any field, any value
					add_poll(1'($urandom_range(0, 1)),
						($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
						12'($urandom), 12'($urandom), $urandom);
					made++;
				end else begin
					// idle release or failed read between gestures
					add_poll(1'($urandom_range(0, 1)), 8'd0, 12'($urandom), 12'($urandom),
						clock_ms);
					made++;
				end
			end
			// sender pause: nothing new until every owed event has come back
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ touch_gesture_recognizer.f @@
rtl/tgr_pkg.sv
rtl/tgr_core.sv
rtl/tgr_outq.sv
rtl/touch_gesture_recognizer.sv
rtl/tgr_checker.sv
dv/tb_top.sv
